// File: rtl/pic_pkg.sv
// Package for the phasor inductor companion block.
// Holds the shared types, register indexes, product-term codes and the
// rounding and saturation helpers. No dependencies.
`default_nettype none

package pic_pkg;

  // Data widths: Q16.16 voltages and currents, Q8.24 coefficients.
  localparam int DATA_W     = 32;
  localparam int COEF_FRAC  = 24;
  localparam int PROD_W     = 2 * DATA_W;
  // Four exact products plus a shifted Q16.16 addend need 66 bits; keep margin.
  localparam int ACC_W      = 68;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COND_RE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COND_IM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_RE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_IM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_GND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_GND  = 3'd5;

  // Terms of a complex product (ar + j ai)(br + j bi).
  localparam logic [1:0] TERM_RR = 2'd0;  // ar*br, added to real part
  localparam logic [1:0] TERM_II = 2'd1;  // ai*bi, subtracted from real part
  localparam logic [1:0] TERM_IR = 2'd2;  // ai*br, added to imaginary part
  localparam logic [1:0] TERM_RI = 2'd3;  // ar*bi, added to imaginary part

  // Control word from the sequencer to the datapath.
  typedef struct packed {
    logic       clear;     // zero both accumulators
    logic       mul_en;    // capture a product
    logic       mul_hist;  // operands H and I instead of G and dV
    logic [1:0] mul_term;  // which term to multiply
    logic       acc_en;    // add the held product
    logic [1:0] acc_term;  // which term the held product is
    logic       cur_load;  // round the accumulators into the current
  } pic_ctrl_t;

  // Difference of two Q16.16 values, saturated to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat_diff(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] d;
    begin
      d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      if (d[DATA_W] != d[DATA_W-1]) begin
        sat_diff = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        sat_diff = d[DATA_W-1:0];
      end
    end
  endfunction

  // Drop the coefficient fraction (half LSB already added) and saturate.
  function automatic logic signed [DATA_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] t
  );
    logic [ACC_W-COEF_FRAC-1:0] s;
    logic                       ovf;
    begin
      s   = t[ACC_W-1:COEF_FRAC];
      ovf = !((&s[ACC_W-COEF_FRAC-1:DATA_W-1]) || !(|s[ACC_W-COEF_FRAC-1:DATA_W-1]));
      if (ovf) begin
        round_sat = s[ACC_W-COEF_FRAC-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        round_sat = s[DATA_W-1:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/pic_if.sv
// Handshake channel interfaces of the phasor inductor companion block.
// One interface for the node voltage words, one for the result words.
// Depends on pic_pkg for the data width.
`default_nettype none

interface pic_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [pic_pkg::DATA_W-1:0] v_pos_re;
  logic signed [pic_pkg::DATA_W-1:0] v_pos_im;
  logic signed [pic_pkg::DATA_W-1:0] v_neg_re;
  logic signed [pic_pkg::DATA_W-1:0] v_neg_im;

  modport source (output valid, v_pos_re, v_pos_im, v_neg_re, v_neg_im, input ready);
  modport sink   (input valid, v_pos_re, v_pos_im, v_neg_re, v_neg_im, output ready);
endinterface

interface pic_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pic_pkg::DATA_W-1:0] cur_re;
  logic signed [pic_pkg::DATA_W-1:0] cur_im;
  logic signed [pic_pkg::DATA_W-1:0] src_re;
  logic signed [pic_pkg::DATA_W-1:0] src_im;

  modport source (output valid, cur_re, cur_im, src_re, src_im, input ready);
  modport sink   (input valid, cur_re, cur_im, src_re, src_im, output ready);
endinterface

`default_nettype wire

// File: rtl/pic_datapath.sv
// Shared multiply-accumulate datapath of the phasor inductor companion block.
// One 32x32 multiplier with a product register, two exact accumulators and
// the current register. Depends on pic_pkg.
`default_nettype none

module pic_datapath (
  input  wire                              clk,
  input  wire pic_pkg::pic_ctrl_t          ctrl,
  input  wire signed [pic_pkg::DATA_W-1:0] cond_re,
  input  wire signed [pic_pkg::DATA_W-1:0] cond_im,
  input  wire signed [pic_pkg::DATA_W-1:0] hist_re,
  input  wire signed [pic_pkg::DATA_W-1:0] hist_im,
  input  wire signed [pic_pkg::DATA_W-1:0] d_re,
  input  wire signed [pic_pkg::DATA_W-1:0] d_im,
  input  wire signed [pic_pkg::DATA_W-1:0] eq_src_re,
  input  wire signed [pic_pkg::DATA_W-1:0] eq_src_im,
  output logic signed [pic_pkg::DATA_W-1:0] cur_re,
  output logic signed [pic_pkg::DATA_W-1:0] cur_im,
  output logic signed [pic_pkg::DATA_W-1:0] src_re,
  output logic signed [pic_pkg::DATA_W-1:0] src_im
);
  import pic_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF_LSB =
    {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};

  logic signed [DATA_W-1:0] ar, ai, br, bi;
  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_re, acc_im;
  logic signed [ACC_W-1:0]  cur_addend_re, cur_addend_im;

  // Operand pairs: G and dV for the current, H and I for the next source.
  always_comb begin
    ar = ctrl.mul_hist ? hist_re : cond_re;
    ai = ctrl.mul_hist ? hist_im : cond_im;
    br = ctrl.mul_hist ? cur_re  : d_re;
    bi = ctrl.mul_hist ? cur_im  : d_im;
    case (ctrl.mul_term)
      TERM_RR: begin op_a = ar; op_b = br; end
      TERM_II: begin op_a = ai; op_b = bi; end
      TERM_IR: begin op_a = ai; op_b = br; end
      TERM_RI: begin op_a = ar; op_b = bi; end
      default: begin op_a = ar; op_b = br; end
    endcase
  end

  // The single multiplier, registered.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= op_a * op_b;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // Exact accumulation; the imaginary-by-imaginary term is subtracted.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (ctrl.acc_en) begin
      case (ctrl.acc_term)
        TERM_RR: acc_re <= acc_re + prod_ext;
        TERM_II: acc_re <= acc_re - prod_ext;
        TERM_IR: acc_im <= acc_im + prod_ext;
        TERM_RI: acc_im <= acc_im + prod_ext;
        default: acc_re <= acc_re;
      endcase
    end
  end

  // Stored source shifted into the accumulator scale, with the half LSB merged in.
  assign cur_addend_re = {{(ACC_W-DATA_W-COEF_FRAC){eq_src_re[DATA_W-1]}}, eq_src_re,
                          1'b1, {(COEF_FRAC-1){1'b0}}};
  assign cur_addend_im = {{(ACC_W-DATA_W-COEF_FRAC){eq_src_im[DATA_W-1]}}, eq_src_im,
                          1'b1, {(COEF_FRAC-1){1'b0}}};

  // The current keeps the raw G*dV sums in the accumulators for the source.
  always_ff @(posedge clk) begin
    if (ctrl.cur_load) begin
      cur_re <= round_sat(acc_re + cur_addend_re);
      cur_im <= round_sat(acc_im + cur_addend_im);
    end
  end

  // Next source once the H*I terms are in.
  assign src_re = round_sat(acc_re + HALF_LSB);
  assign src_im = round_sat(acc_im + HALF_LSB);

endmodule

`default_nettype wire

// File: rtl/phasor_inductor_companion.sv
// Top level of the phasor inductor companion block (trapezoidal rule).
// Sequencer, configuration registers, stored source and result register.
// Depends on pic_pkg, pic_if and pic_datapath.
// Usage:
//   volt carries one word per simulation time step: the complex voltages of
//   both inductor ends, Q16.16. result returns one word per step: the branch
//   current and the next equivalent source, Q16.16, saturated.
//   The configuration port writes conductance, history factor and the two
//   ground flags by index; write only while the block is idle.
// Timing:
//   A word is accepted when volt.ready is high, which it is only while the
//   sequencer is idle; a new word waits until the previous one has reached
//   the output register. The schedule is set by the one shared 32x32
//   multiplier: eight products, four for G*dV and four for H*I, each followed
//   by one accumulate, plus the rounding steps.
// Reset and stalls:
//   Reset clears the configuration registers, the sequencer state, the stored source and all valid state.
//   The result waits in its register while result.ready is low; a new word
//   may be accepted meanwhile, and its final step waits until the register
//   is free, so the stored source advances exactly once per step.
`default_nettype none

module phasor_inductor_companion (
  input  wire                                 clk,
  input  wire                                 rst,
  pic_in_if.sink                              volt,
  pic_out_if.source                           result,
  input  wire                                 wr_en,
  input  wire [pic_pkg::CFG_IDX_W-1:0]        wr_index,
  input  wire [pic_pkg::CFG_DATA_W-1:0]       wr_data
);
  import pic_pkg::*;

  // Sequencer states and step numbers.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [3:0] STEP_CUR  = 4'd5;
  localparam logic [3:0] STEP_HIST = 4'd6;
  localparam logic [3:0] STEP_LAST = 4'd10;

  logic [1:0]               state, state_next;
  logic [3:0]               step;
  logic                     accept;
  logic                     fin_go;
  pic_ctrl_t                ctrl;

  logic signed [DATA_W-1:0] cond_re, cond_im, hist_re, hist_im;
  logic                     pos_grounded, neg_grounded;
  logic signed [DATA_W-1:0] eq_src_re, eq_src_im;
  logic signed [DATA_W-1:0] d_re, d_im;
  logic signed [DATA_W-1:0] vp_re, vp_im, vn_re, vn_im;
  logic signed [DATA_W-1:0] cur_re, cur_im, src_re, src_im;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_cur_re, out_cur_im, out_src_re, out_src_im;

  assign accept = volt.valid && volt.ready;
  assign fin_go = (state == S_FIN) && (!out_valid || result.ready);

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cond_re      <= '0;
      cond_im      <= '0;
      hist_re      <= '0;
      hist_im      <= '0;
      pos_grounded <= 1'b0;
      neg_grounded <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_COND_RE: cond_re      <= wr_data[DATA_W-1:0];
        REG_COND_IM: cond_im      <= wr_data[DATA_W-1:0];
        REG_HIST_RE: hist_re      <= wr_data[DATA_W-1:0];
        REG_HIST_IM: hist_im      <= wr_data[DATA_W-1:0];
        REG_POS_GND: pos_grounded <= wr_data[0];
        REG_NEG_GND: neg_grounded <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Grounded ends read as zero; the difference is captured on acceptance.
  assign vp_re = pos_grounded ? '0 : volt.v_pos_re;
  assign vp_im = pos_grounded ? '0 : volt.v_pos_im;
  assign vn_re = neg_grounded ? '0 : volt.v_neg_re;
  assign vn_im = neg_grounded ? '0 : volt.v_neg_im;

  always_ff @(posedge clk) begin
    if (accept) begin
      d_re <= sat_diff(vp_re, vn_re);
      d_im <= sat_diff(vp_im, vn_im);
    end
  end

  // State and step counter.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_RUN;
      S_RUN:   if (step == STEP_LAST) state_next = S_FIN;
      S_FIN:   if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_RUN) begin
        step <= step + 4'd1;
      end else begin
        step <= '0;
      end
    end
  end

  // Step schedule: each product is captured in the product register, then accumulated.
  always_comb begin
    ctrl          = '0;
    ctrl.clear    = accept;
    ctrl.cur_load = (state == S_RUN) && (step == STEP_CUR);
    if (state == S_RUN) begin
      if (step < 4'd4) begin
        ctrl.mul_en   = 1'b1;
        ctrl.mul_term = step[1:0];
      end else if (step >= STEP_HIST && step < STEP_HIST + 4'd4) begin
        ctrl.mul_en   = 1'b1;
        ctrl.mul_hist = 1'b1;
        ctrl.mul_term = 2'(step - STEP_HIST);
      end
      if (step >= 4'd1 && step <= 4'd4) begin
        ctrl.acc_en   = 1'b1;
        ctrl.acc_term = 2'(step - 4'd1);
      end else if (step >= STEP_HIST + 4'd1 && step <= STEP_LAST) begin
        ctrl.acc_en   = 1'b1;
        ctrl.acc_term = 2'(step - STEP_HIST - 4'd1);
      end
    end
  end

  pic_datapath u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .cond_re   (cond_re),
    .cond_im   (cond_im),
    .hist_re   (hist_re),
    .hist_im   (hist_im),
    .d_re      (d_re),
    .d_im      (d_im),
    .eq_src_re (eq_src_re),
    .eq_src_im (eq_src_im),
    .cur_re    (cur_re),
    .cur_im    (cur_im),
    .src_re    (src_re),
    .src_im    (src_im)
  );

  // Stored source advances when the result is handed to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      eq_src_re <= '0;
      eq_src_im <= '0;
    end else if (fin_go) begin
      eq_src_re <= src_re;
      eq_src_im <= src_im;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_cur_re <= cur_re;
      out_cur_im <= cur_im;
      out_src_re <= src_re;
      out_src_im <= src_im;
    end
  end

  assign volt.ready    = (state == S_IDLE);
  assign result.valid  = out_valid;
  assign result.cur_re = out_cur_re;
  assign result.cur_im = out_cur_im;
  assign result.src_re = out_src_re;
  assign result.src_im = out_src_im;

endmodule

`default_nettype wire

// File: rtl/pic_checker.sv
// Port-level checks for the phasor inductor companion block.
// Watches only the top-level ports; attached to the top level by a bind.
// Depends on pic_pkg for the data width.
`default_nettype none

module pic_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [pic_pkg::DATA_W-1:0]  cur_re,
  input wire [pic_pkg::DATA_W-1:0]  src_re
);

  // Reset leaves no result word pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // One word at a time: the block is busy right after accepting one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // A result cannot appear early, right after acceptance.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too early");

  // A stalled result word holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cur_re) && $stable(src_re)))
    else $error("stalled result changed");

endmodule

bind phasor_inductor_companion pic_checker u_pic_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (volt.valid),
  .in_ready  (volt.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .cur_re    (result.cur_re),
  .src_re    (result.src_re)
);

`default_nettype wire
